### sv/bmhq_pkg.sv
// bigram max-heap queue package: entry type, mode and status codes, sizing
// shared by the front end, the heap engine and the top level; no dependencies
package bmhq_pkg;

    localparam int unsigned MaxEntriesDefault = 1024;
    localparam int unsigned CapWidth          = 11;
    localparam int unsigned QueueDepth        = 2;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [31:0] score;
        logic [15:0] left;
        logic [31:0] payload;
    } entry_t;

    localparam int unsigned EntryWidth = $bits(entry_t);

    // classified command handed from the front end to the heap engine
    typedef struct packed {
        op_t     op;
        status_t status;
        entry_t  entry;
    } cmd_t;

    // true if entry a strictly outranks entry b
    function automatic logic higher(input entry_t a, input entry_t b);
        logic result;
        if (a.score != b.score) begin
            result = ($signed(a.score) > $signed(b.score));
        end else begin
            result = (a.left < b.left);
        end
        return result;
    endfunction

endpackage

### sv/bigram_max_heap_queue_core.sv
// heap queue top: engine time per item grows with the levels a push climbs
// or a pop sinks, while queries and flagged items need no heap walk;
// one single-port ram sets the pace
// an input beat is registered in the command queue before it reaches the engine; one item in the engine
// a two-entry command queue lets the next beat be taken while one is worked
// reset (aresetn low, synchronous): empty queue, capacity 1024, heap ram unset
module bigram_max_heap_queue_core #(
    parameter int unsigned MaxEntries = bmhq_pkg::MaxEntriesDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mode[1:0], entry_score[33:2], entry_left[49:34], entry_payload[81:50], zero fill
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // top_valid[0], top_score[32:1], top_left[48:33], top_payload[80:49],
    // entry_count[91:81], status[93:92], zero fill
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CntW = $clog2(MaxEntries + 1);

    logic [bmhq_pkg::CapWidth-1:0] capacity_reg;
    bmhq_pkg::entry_t              in_entry, top;
    bmhq_pkg::cmd_t                cmd;
    logic                          cmd_valid, cmd_ready, top_valid;
    logic [CntW-1:0]               count_after;
    logic [bmhq_pkg::CapWidth-1:0] count;
    bmhq_pkg::status_t             status;

    // capacity register
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, capacity_reg} : 32'd0;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= bmhq_pkg::CapWidth'(1024);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            capacity_reg <= pwdata[bmhq_pkg::CapWidth-1:0];
        end
    end

    assign in_entry.score   = s_tdata[33:2];
    assign in_entry.left    = s_tdata[49:34];
    assign in_entry.payload = s_tdata[81:50];

    bmhq_front #(.MaxEntries(MaxEntries)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tdata[1:0]),
        .in_entry    (in_entry),
        .capacity    (capacity_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .count_after (count_after)
    );

    bmhq_engine #(.MaxEntries(MaxEntries)) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .count_after   (count_after),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_top_valid (top_valid),
        .out_top       (top),
        .out_count     (count),
        .out_status    (status)
    );

    assign m_tdata = {2'b00, status, count, top.payload, top.left, top.score, top_valid};

endmodule

### sv/bmhq_ram.sv
// generic single-port ram with registered read
// no dependencies
module bmhq_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // write through the one port, read data registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### sv/bmhq_front.sv
// front end: takes input beats, tracks the count and classifies each beat
// depends on bmhq_pkg; feeds the command queue of the heap engine
module bmhq_front #(
    parameter int unsigned MaxEntries = bmhq_pkg::MaxEntriesDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_mode,
    input  bmhq_pkg::entry_t              in_entry,
    input  logic [bmhq_pkg::CapWidth-1:0] capacity,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output bmhq_pkg::cmd_t                cmd,
    output logic [$clog2(MaxEntries+1)-1:0] count_after
);

    localparam int unsigned CntW = $clog2(MaxEntries + 1);
    localparam int unsigned Qw   = $clog2(bmhq_pkg::QueueDepth);

    logic [CntW-1:0]       count_reg, count_next;
    bmhq_pkg::cmd_t        q_reg [bmhq_pkg::QueueDepth];
    logic [CntW-1:0]       qc_reg [bmhq_pkg::QueueDepth];
    logic [Qw-1:0]         wp_reg, rp_reg;
    logic [Qw:0]           fill_reg;
    logic [CntW:0]         limit;
    bmhq_pkg::cmd_t        new_cmd;
    logic                  take, give;

    assign in_ready  = (fill_reg != (Qw+1)'(bmhq_pkg::QueueDepth));
    assign take      = in_valid && in_ready;
    assign give      = cmd_valid && cmd_ready;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rp_reg];
    assign count_after = qc_reg[rp_reg];

    // effective limit: capacity clamped to the storage depth
    always_comb begin
        if ({{(CntW+1 > bmhq_pkg::CapWidth ? CntW+1-bmhq_pkg::CapWidth : 0){1'b0}}, capacity}
                > (CntW+1)'(MaxEntries)) begin
            limit = (CntW+1)'(MaxEntries);
        end else begin
            limit = (CntW+1)'(capacity);
        end
    end

    // classify the beat against the running count
    always_comb begin
        new_cmd.entry  = in_entry;
        new_cmd.status = bmhq_pkg::ST_OK;
        new_cmd.op     = bmhq_pkg::OP_QUERY;
        count_next     = count_reg;
        unique case (bmhq_pkg::mode_t'(in_mode))
            bmhq_pkg::MODE_PUSH: begin
                if ({1'b0, count_reg} >= limit) begin
                    new_cmd.status = bmhq_pkg::ST_FULL;
                end else begin
                    new_cmd.op = bmhq_pkg::OP_PUSH;
                    count_next = count_reg + 1'b1;
                end
            end
            bmhq_pkg::MODE_POP: begin
                if (count_reg == '0) begin
                    new_cmd.status = bmhq_pkg::ST_EMPTY;
                end else begin
                    new_cmd.op = bmhq_pkg::OP_POP;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                new_cmd.op = bmhq_pkg::OP_QUERY;
            end
        endcase
    end

    // command queue and running count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
        end else begin
            if (take) begin
                count_reg      <= count_next;
                q_reg[wp_reg]  <= new_cmd;
                qc_reg[wp_reg] <= count_next;
                wp_reg         <= wp_reg + 1'b1;
            end
            if (give) begin
                rp_reg <= rp_reg + 1'b1;
            end
            fill_reg <= fill_reg + (Qw+1)'(take) - (Qw+1)'(give);
        end
    end

endmodule

### sv/bmhq_engine.sv
// heap engine: carries out push sift-up and pop sift-down on the heap ram,
// keeps the root in a register and drives the output register; uses bmhq_ram
module bmhq_engine #(
    parameter int unsigned MaxEntries = bmhq_pkg::MaxEntriesDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  bmhq_pkg::cmd_t                cmd,
    input  logic [$clog2(MaxEntries+1)-1:0] count_after,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_top_valid,
    output bmhq_pkg::entry_t              out_top,
    output logic [bmhq_pkg::CapWidth-1:0] out_count,
    output bmhq_pkg::status_t             out_status
);

    localparam int unsigned CntW = $clog2(MaxEntries + 1);
    localparam int unsigned AW   = $clog2(MaxEntries);

    typedef enum logic [2:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DONE
    } state_t;

    state_t                  state_reg;
    // heap slot numbers are 1-based, ram address is slot - 1
    logic [CntW-1:0]         idx_reg;
    logic [CntW-1:0]         cnt_reg;
    bmhq_pkg::entry_t        cur_reg;
    bmhq_pkg::entry_t        left_reg;
    bmhq_pkg::entry_t        root_reg;
    bmhq_pkg::status_t       status_reg;
    logic                    ov_reg;
    logic                    otv_reg;
    bmhq_pkg::entry_t        otop_reg;
    logic [bmhq_pkg::CapWidth-1:0] ocnt_reg;
    bmhq_pkg::status_t       ost_reg;

    logic                    we;
    logic [AW-1:0]           addr;
    bmhq_pkg::entry_t        wdata, rdata;
    logic [CntW:0]           lchild, rchild;
    logic [CntW-1:0]         parent;
    bmhq_pkg::entry_t        best;
    logic                    rsel;
    logic                    swap;

    bmhq_ram #(.Width(bmhq_pkg::EntryWidth), .Depth(MaxEntries)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign lchild    = {idx_reg, 1'b0};
    assign rchild    = {idx_reg, 1'b1};
    assign parent    = idx_reg >> 1;
    assign cmd_ready = (state_reg == S_IDLE) && !(ov_reg && !out_ready);

    // better child and whether it beats the sinking entry
    assign rsel = (rchild <= {1'b0, cnt_reg}) && bmhq_pkg::higher(rdata, left_reg);
    assign best = rsel ? rdata : left_reg;
    assign swap = (lchild <= {1'b0, cnt_reg}) && bmhq_pkg::higher(best, cur_reg);

    assign out_valid     = ov_reg;
    assign out_top_valid = otv_reg;
    assign out_top       = otop_reg;
    assign out_count     = ocnt_reg;
    assign out_status    = ost_reg;

    // ram port steering per state
    always_comb begin
        we    = 1'b0;
        addr  = '0;
        wdata = cur_reg;
        unique case (state_reg)
            S_IDLE: begin
                // pop reads the last slot; push writes its new slot
                if (cmd_valid && cmd_ready) begin
                    if (cmd.op == bmhq_pkg::OP_PUSH) begin
                        we    = 1'b1;
                        addr  = AW'(count_after - 1'b1);
                        wdata = cmd.entry;
                    end else begin
                        addr = AW'(count_after);
                    end
                end
            end
            S_UP_RD: begin
                // at the root the climbing entry settles in slot 1
                if (idx_reg <= CntW'(1)) begin
                    we   = 1'b1;
                    addr = '0;
                end else begin
                    addr = AW'(parent - 1'b1);
                end
            end
            S_UP_CMP: begin
                we   = 1'b1;
                addr = AW'(idx_reg - 1'b1);
                wdata = bmhq_pkg::higher(cur_reg, rdata) ? rdata : cur_reg;
            end
            S_DN_RDL: addr = AW'(lchild - 1'b1);
            S_DN_RDR: addr = AW'(rchild - 1'b1);
            S_DN_CMP: begin
                // the winning child moves up, else the sinking entry settles
                we    = 1'b1;
                addr  = AW'(idx_reg - 1'b1);
                wdata = swap ? best : cur_reg;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // sequencer, root register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        status_reg <= cmd.status;
                        cnt_reg    <= count_after;
                        idx_reg    <= count_after;
                        cur_reg    <= cmd.entry;
                        unique case (cmd.op)
                            bmhq_pkg::OP_PUSH: begin
                                state_reg <= S_UP_RD;
                            end
                            bmhq_pkg::OP_POP: begin
                                idx_reg   <= CntW'(1);
                                state_reg <= S_DN_RDL;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_UP_RD: begin
                    if (idx_reg <= CntW'(1)) begin
                        root_reg  <= cur_reg;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    // parent data now in rdata; move it down if the new entry wins
                    if (bmhq_pkg::higher(cur_reg, rdata)) begin
                        idx_reg   <= parent;
                        state_reg <= S_UP_RD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DN_RDL: begin
                    // the pass at the root catches the last entry read from the idle state
                    if (idx_reg == CntW'(1)) begin
                        cur_reg <= rdata;
                    end
                    if (lchild > {1'b0, cnt_reg}) begin
                        state_reg <= S_DN_CMP;
                    end else begin
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR: begin
                    left_reg  <= rdata;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    // swap with the better child if it beats the moving entry
                    if (swap) begin
                        if (idx_reg == CntW'(1)) begin
                            root_reg <= best;
                        end
                        idx_reg   <= rsel ? rchild[CntW-1:0] : lchild[CntW-1:0];
                        state_reg <= S_DN_RDL;
                    end else begin
                        if (idx_reg == CntW'(1)) begin
                            root_reg <= cur_reg;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!ov_reg || out_ready) begin
                        ov_reg    <= 1'b1;
                        otv_reg   <= (cnt_reg != '0);
                        otop_reg  <= (cnt_reg != '0) ? root_reg : '0;
                        ocnt_reg  <= bmhq_pkg::CapWidth'(cnt_reg);
                        ost_reg   <= status_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/bmhq_checker.sv
// port checker for the heap queue top; binds to bigram_max_heap_queue_core
// depends on nothing but the top level's ports
module bmhq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a result beat held under stall keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // top_valid matches a nonzero count
    a_topv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[91:81] != 11'd0)))
        else $error("top_valid disagrees with count");

    // empty queue shows a zero top entry
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[80:1] == 80'd0)
        else $error("empty queue top not zero");

    // status code is never the unused one
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[93:92] != 2'd3)
        else $error("bad status");

endmodule

bind bigram_max_heap_queue_core bmhq_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
